// ===== hw/rtl/h264sps_pkg.sv =====
`default_nettype none
package h264sps_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_SPS   = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_CROP      = 3'd4
  } status_e;

  localparam logic [4:0] NalTypeSps = 5'd7;
  localparam logic [7:0] EmulByte   = 8'h03;

  // Summary of the decoded fields that the top level needs at the end of a unit.
  typedef struct packed {
    logic              done;
    logic              long_err;
    logic [1:0]        chroma;
    logic              frame_only;
    logic [31:0]       width_mbs;
    logic [31:0]       height_units;
    logic [3:0][31:0]  crop;
  } parse_info_t;

endpackage
`default_nettype wire

// ===== hw/rtl/h264sps_bit_parser.sv =====
`default_nettype none
module h264sps_bit_parser #(
  parameter int MAX_REF_CYCLE = 256
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clear_i,
  input  wire logic                      start_i,
  input  wire logic                      bit_valid_i,
  input  wire logic                      bit_i,
  output h264sps_pkg::parse_info_t       info_o
);

  localparam int CoefW = ($clog2(MAX_REF_CYCLE + 1) > 7) ? $clog2(MAX_REF_CYCLE + 1) : 7;
  localparam logic [CoefW-1:0] MaxCycle = CoefW'(MAX_REF_CYCLE);

  typedef enum logic [4:0] {
    PH_HEADER, PH_PROFILE, PH_SKIP16, PH_SPS_ID, PH_CHROMA_FMT, PH_SEP_PLANE,
    PH_BD_LUMA, PH_BD_CHROMA, PH_BYPASS, PH_MATRIX, PH_LIST_FLAG, PH_LIST_DELTA,
    PH_FRAME_NUM, PH_POC_TYPE, PH_POC_LSB, PH_DELTA_ZERO, PH_OFF_NONREF,
    PH_OFF_TB, PH_CYCLE_LEN, PH_CYCLE_OFF, PH_MAX_REF, PH_GAPS, PH_WIDTH,
    PH_HEIGHT, PH_FRAME_ONLY, PH_MBAFF, PH_DIRECT, PH_CROP_FLAG, PH_CROP,
    PH_DONE, PH_SINK
  } phase_e;

  // Width of a fixed-length field; zero means the field is Exp-Golomb coded.
  function automatic logic [4:0] field_bits(phase_e p);
    case (p)
      PH_PROFILE:                          return 5'd8;
      PH_SKIP16:                           return 5'd16;
      PH_SEP_PLANE, PH_BYPASS, PH_MATRIX,
      PH_LIST_FLAG, PH_DELTA_ZERO, PH_GAPS,
      PH_FRAME_ONLY, PH_MBAFF, PH_DIRECT,
      PH_CROP_FLAG:                        return 5'd1;
      default:                             return 5'd0;
    endcase
  endfunction

  function automatic logic chroma_profile(logic [7:0] p);
    case (p)
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
      8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135: return 1'b1;
      default:                                        return 1'b0;
    endcase
  endfunction

  phase_e            phase_q, phase_d;
  logic [5:0]        zeros_q, zeros_d;
  logic [31:0]       gv_q, gv_d;
  logic              suffix_q, suffix_d;
  logic [4:0]        bits_q, bits_d;
  logic [7:0]        profile_q, profile_d;
  logic [1:0]        chroma_q, chroma_d;
  logic [3:0]        list_q, list_d;
  logic [CoefW-1:0]  coef_q, coef_d;
  logic [7:0]        last_scale_q, last_scale_d;
  logic [CoefW-1:0]  cycle_q, cycle_d;
  logic [31:0]       width_q, width_d;
  logic [31:0]       height_q, height_d;
  logic              frame_only_q, frame_only_d;
  logic [3:0][31:0]  crop_q, crop_d;
  logic              long_q, long_d;

  logic              adv;
  logic [31:0]       v, vp1, gv_n;
  logic [4:0]        bits_n;
  logic              do_enter;
  phase_e            nxt;
  logic [7:0]        delta, scale_sum;
  logic [3:0]        list_n;
  logic [CoefW-1:0]  coef_n;

  always_comb begin
    phase_d = phase_q; zeros_d = zeros_q; gv_d = gv_q; suffix_d = suffix_q;
    bits_d = bits_q; profile_d = profile_q; chroma_d = chroma_q; list_d = list_q;
    coef_d = coef_q; last_scale_d = last_scale_q; cycle_d = cycle_q;
    width_d = width_q; height_d = height_q; frame_only_d = frame_only_q;
    crop_d = crop_q; long_d = long_q;
    adv = 1'b0; v = '0; vp1 = 32'd1; do_enter = 1'b0; nxt = phase_q;
    gv_n = {gv_q[30:0], bit_i};
    bits_n = (bits_q != 5'd0) ? bits_q - 5'd1 : 5'd0;
    delta = '0; scale_sum = '0; list_n = list_q + 4'd1; coef_n = coef_q + 1'b1;

    if (bit_valid_i && phase_q != PH_HEADER && phase_q != PH_DONE && phase_q != PH_SINK) begin
      if (field_bits(phase_q) != 5'd0) begin
        gv_d = gv_n;
        bits_d = bits_n;
        if (bits_n == 5'd0) begin
          adv = 1'b1;
          v = gv_n;
        end
      end else if (!suffix_q) begin
        if (!bit_i) begin
          zeros_d = zeros_q + 6'd1;
          if (zeros_q + 6'd1 > 6'd31) begin
            long_d = 1'b1;
            phase_d = PH_SINK;
          end
        end else if (zeros_q == 6'd0) begin
          adv = 1'b1;
        end else begin
          suffix_d = 1'b1;
          bits_d = zeros_q[4:0];
          gv_d = '0;
        end
      end else begin
        gv_d = gv_n;
        bits_d = bits_n;
        if (bits_n == 5'd0) begin
          adv = 1'b1;
          // The suffix is below the leading power of two, so OR forms the sum.
          vp1 = (32'd1 << zeros_q[4:0]) | gv_n;
          v = vp1 - 32'd1;
        end
      end
    end

    if (adv) begin
      do_enter = 1'b1;
      case (phase_q)
        PH_PROFILE: begin
          profile_d = v[7:0];
          nxt = PH_SKIP16;
        end
        PH_SKIP16:   nxt = PH_SPS_ID;
        PH_SPS_ID:   nxt = chroma_profile(profile_q) ? PH_CHROMA_FMT : PH_FRAME_NUM;
        PH_CHROMA_FMT: begin
          chroma_d = (v <= 32'd3) ? v[1:0] : 2'd0;
          nxt = (v == 32'd3) ? PH_SEP_PLANE : PH_BD_LUMA;
        end
        PH_SEP_PLANE: nxt = PH_BD_LUMA;
        PH_BD_LUMA:   nxt = PH_BD_CHROMA;
        PH_BD_CHROMA: nxt = PH_BYPASS;
        PH_BYPASS:    nxt = PH_MATRIX;
        PH_MATRIX: begin
          list_d = '0;
          nxt = v[0] ? PH_LIST_FLAG : PH_FRAME_NUM;
        end
        PH_LIST_FLAG: begin
          if (v[0]) begin
            coef_d = '0;
            last_scale_d = 8'd8;
            nxt = PH_LIST_DELTA;
          end else begin
            list_d = list_n;
            nxt = (list_n >= ((chroma_q == 2'd3) ? 4'd12 : 4'd8)) ? PH_FRAME_NUM
                                                                  : PH_LIST_FLAG;
          end
        end
        PH_LIST_DELTA: begin
          delta = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
          scale_sum = last_scale_q + delta;
          if (scale_sum != 8'd0) last_scale_d = scale_sum;
          coef_d = coef_n;
          if (coef_n >= ((list_q < 4'd6) ? CoefW'(16) : CoefW'(64)) || scale_sum == 8'd0)
          begin
            list_d = list_n;
            nxt = (list_n >= ((chroma_q == 2'd3) ? 4'd12 : 4'd8)) ? PH_FRAME_NUM
                                                                  : PH_LIST_FLAG;
          end else begin
            nxt = PH_LIST_DELTA;
          end
        end
        PH_FRAME_NUM: nxt = PH_POC_TYPE;
        PH_POC_TYPE:
          nxt = (v == 32'd0) ? PH_POC_LSB : (v == 32'd1) ? PH_DELTA_ZERO : PH_MAX_REF;
        PH_POC_LSB:    nxt = PH_MAX_REF;
        PH_DELTA_ZERO: nxt = PH_OFF_NONREF;
        PH_OFF_NONREF: nxt = PH_OFF_TB;
        PH_OFF_TB:     nxt = PH_CYCLE_LEN;
        PH_CYCLE_LEN: begin
          cycle_d = (v < 32'(MAX_REF_CYCLE)) ? v[CoefW-1:0] : MaxCycle;
          coef_d = '0;
          nxt = (v != 32'd0) ? PH_CYCLE_OFF : PH_MAX_REF;
        end
        PH_CYCLE_OFF: begin
          coef_d = coef_n;
          nxt = (coef_n >= cycle_q) ? PH_MAX_REF : PH_CYCLE_OFF;
        end
        PH_MAX_REF: nxt = PH_GAPS;
        PH_GAPS:    nxt = PH_WIDTH;
        PH_WIDTH: begin
          width_d = vp1;
          nxt = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_d = vp1;
          nxt = PH_FRAME_ONLY;
        end
        PH_FRAME_ONLY: begin
          frame_only_d = v[0];
          nxt = v[0] ? PH_DIRECT : PH_MBAFF;
        end
        PH_MBAFF:  nxt = PH_DIRECT;
        PH_DIRECT: nxt = PH_CROP_FLAG;
        PH_CROP_FLAG: begin
          list_d = '0;
          nxt = v[0] ? PH_CROP : PH_DONE;
        end
        PH_CROP: begin
          crop_d[list_q[1:0]] = v;
          list_d = list_n;
          nxt = (list_n >= 4'd4) ? PH_DONE : PH_CROP;
        end
        default: do_enter = 1'b0;
      endcase
    end

    if (start_i) begin
      do_enter = 1'b1;
      nxt = PH_PROFILE;
    end

    if (do_enter) begin
      phase_d = nxt;
      bits_d = field_bits(nxt);
      zeros_d = '0;
      gv_d = '0;
      suffix_d = 1'b0;
    end

    // Closing a unit brings every field back to its reset value.
    if (clear_i) begin
      phase_d = PH_HEADER; zeros_d = '0; gv_d = '0; suffix_d = 1'b0;
      bits_d = '0; profile_d = '0; chroma_d = 2'd1; list_d = '0;
      coef_d = '0; last_scale_d = 8'd8; cycle_d = '0; width_d = '0;
      height_d = '0; frame_only_d = 1'b0; crop_d = '0; long_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; zeros_q <= '0; gv_q <= '0; suffix_q <= 1'b0;
      bits_q <= '0; profile_q <= '0; chroma_q <= 2'd1; list_q <= '0;
      coef_q <= '0; last_scale_q <= 8'd8; cycle_q <= '0; width_q <= '0;
      height_q <= '0; frame_only_q <= 1'b0; crop_q <= '0; long_q <= 1'b0;
    end else begin
      phase_q <= phase_d; zeros_q <= zeros_d; gv_q <= gv_d; suffix_q <= suffix_d;
      bits_q <= bits_d; profile_q <= profile_d; chroma_q <= chroma_d; list_q <= list_d;
      coef_q <= coef_d; last_scale_q <= last_scale_d; cycle_q <= cycle_d;
      width_q <= width_d; height_q <= height_d; frame_only_q <= frame_only_d;
      crop_q <= crop_d; long_q <= long_d;
    end
  end

  assign info_o.done         = (phase_q == PH_DONE);
  assign info_o.long_err     = long_q;
  assign info_o.chroma       = chroma_q;
  assign info_o.frame_only   = frame_only_q;
  assign info_o.width_mbs    = width_q;
  assign info_o.height_units = height_q;
  assign info_o.crop         = crop_q;

endmodule
`default_nettype wire

// ===== hw/rtl/h264_sps_dimension_parser.sv =====
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i / in_stall_o | data_byte_i, last_byte_i, empty_marker_i
// output  | out       | out_valid_o / out_stall_i | pic_width_o, pic_height_o, status_o
//
// A data byte is accepted in S_IDLE and then shifted through S_BITS, in which the bit parser
// takes one bit a cycle. The header byte and a dropped 0x03 are handled on acceptance alone.
// The end of a unit passes through S_SUM for the crop sums and S_DONE for the final compare.
// Reset clears all parsing state; no memory needs a clearing pass.
// The final result waits in the output register while out_stall_i is high.
`default_nettype none
module h264_sps_dimension_parser #(
  parameter int MAX_REF_CYCLE = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        empty_marker_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      pic_width_o,
  output logic [31:0]      pic_height_o,
  output logic [2:0]       status_o
);

  typedef enum logic [1:0] {S_IDLE, S_BITS, S_SUM, S_DONE} state_e;

  state_e                   state_q;
  logic [7:0]               byte_q;
  logic                     last_q;
  logic [2:0]               cnt_q;
  logic                     started_q;
  logic                     not_sps_q;
  logic [1:0]               zero_run_q;
  logic [31:0]              sum_x_q, sum_y_q;
  logic                     out_valid_q;
  logic [31:0]              width_q, height_q;
  logic [2:0]               status_q;

  logic                     accept;
  logic                     start, clear, bit_valid;
  h264sps_pkg::parse_info_t info;

  logic [37:0]              cw, ch, cx, cy;
  logic                     out_free;
  h264sps_pkg::status_e     fin_status;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign start     = accept && !empty_marker_i && !started_q &&
                     (data_byte_i[4:0] == h264sps_pkg::NalTypeSps);
  assign bit_valid = (state_q == S_BITS);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign clear     = (state_q == S_DONE) && out_free;

  h264sps_bit_parser #(
    .MAX_REF_CYCLE(MAX_REF_CYCLE)
  ) u_bits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .start_i     (start),
    .bit_valid_i (bit_valid),
    .bit_i       (byte_q[cnt_q]),
    .info_o      (info)
  );

  // Coded size and crop in luma samples, all in 38 bits for the compare.
  always_comb begin
    cw = {2'b0, info.width_mbs, 4'b0};
    ch = info.frame_only ? {2'b0, info.height_units, 4'b0} : {1'b0, info.height_units, 5'b0};
    cx = (info.chroma == 2'd1 || info.chroma == 2'd2) ? {5'b0, sum_x_q, 1'b0}
                                                      : {6'b0, sum_x_q};
    case ({info.chroma == 2'd1, !info.frame_only})
      2'b11:   cy = {4'b0, sum_y_q, 2'b0};
      2'b10,
      2'b01:   cy = {5'b0, sum_y_q, 1'b0};
      default: cy = {6'b0, sum_y_q};
    endcase
    if (!started_q) begin
      fin_status = h264sps_pkg::ST_EMPTY;
    end else if (not_sps_q) begin
      fin_status = h264sps_pkg::ST_NOT_SPS;
    end else if (info.long_err || !info.done) begin
      fin_status = h264sps_pkg::ST_TRUNCATED;
    end else if (cx >= cw || cy >= ch) begin
      fin_status = h264sps_pkg::ST_CROP;
    end else begin
      fin_status = h264sps_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; byte_q <= '0; last_q <= 1'b0; cnt_q <= '0;
      started_q <= 1'b0; not_sps_q <= 1'b0; zero_run_q <= '0;
      sum_x_q <= '0; sum_y_q <= '0; out_valid_q <= 1'b0;
      width_q <= '0; height_q <= '0; status_q <= '0;
    end else begin
      // A new word is loaded as the old one leaves or while the register is empty.
      out_valid_q <= clear || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            byte_q <= data_byte_i;
            last_q <= last_byte_i;
            cnt_q  <= 3'd7;
            if (empty_marker_i) begin
              state_q <= S_SUM;
            end else if (!started_q) begin
              started_q <= 1'b1;
              not_sps_q <= !start;
              state_q   <= last_byte_i ? S_SUM : S_IDLE;
            end else if (zero_run_q == 2'd2 && data_byte_i == h264sps_pkg::EmulByte) begin
              // An emulation-prevention byte is dropped and restarts the count.
              zero_run_q <= '0;
              state_q    <= last_byte_i ? S_SUM : S_IDLE;
            end else begin
              zero_run_q <= (data_byte_i != 8'd0) ? 2'd0
                          : (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
              state_q    <= S_BITS;
            end
          end
        end
        S_BITS: begin
          cnt_q <= cnt_q - 3'd1;
          if (cnt_q == 3'd0) state_q <= last_q ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          sum_x_q <= info.crop[0] + info.crop[1];
          sum_y_q <= info.crop[2] + info.crop[3];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            status_q    <= fin_status;
            width_q     <= (fin_status == h264sps_pkg::ST_OK) ? 32'(cw - cx) : 32'd0;
            height_q    <= (fin_status == h264sps_pkg::ST_OK) ? 32'(ch - cy) : 32'd0;
            started_q   <= 1'b0;
            not_sps_q   <= 1'b0;
            zero_run_q  <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign pic_width_o  = width_q;
  assign pic_height_o = height_q;
  assign status_o     = status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/h264sps_checker.sv =====
`default_nettype none
module h264sps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        empty_marker_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] pic_width_o,
  input wire logic [31:0] pic_height_o,
  input wire logic [2:0]  status_o
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == h264sps_pkg::ST_OK || status_o == h264sps_pkg::ST_EMPTY ||
                     status_o == h264sps_pkg::ST_NOT_SPS ||
                     status_o == h264sps_pkg::ST_TRUNCATED || status_o == h264sps_pkg::ST_CROP))
    else $error("status out of range");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != h264sps_pkg::ST_OK) |-> (pic_width_o == 32'd0 &&
                                                         pic_height_o == 32'd0))
    else $error("size not zero with error status");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && empty_marker_i) |=> in_stall_o)
    else $error("input taken while a unit is being closed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled word changed");

endmodule

bind h264_sps_dimension_parser h264sps_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .empty_marker_i (empty_marker_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pic_width_o    (pic_width_o),
  .pic_height_o   (pic_height_o),
  .status_o       (status_o)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

  localparam int CycleCap = 256;

  typedef enum int {
    P_HEADER, P_PROFILE, P_SKIP16, P_SPS_ID, P_CHROMA_FMT, P_SEP_PLANE,
    P_BD_LUMA, P_BD_CHROMA, P_BYPASS, P_MATRIX, P_LIST_FLAG, P_LIST_DELTA,
    P_FRAME_NUM, P_POC_TYPE, P_POC_LSB, P_DELTA_ZERO, P_OFF_NONREF,
    P_OFF_TB, P_CYCLE_LEN, P_CYCLE_OFF, P_MAX_REF, P_GAPS, P_WIDTH,
    P_HEIGHT, P_FRAME_ONLY, P_MBAFF, P_DIRECT, P_CROP_FLAG, P_CROP,
    P_DONE, P_SINK
  } phase_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       empty;
    bit         drain;
  } word_t;

  typedef struct {
    logic [31:0] width;
    logic [31:0] height;
    logic [2:0]  status;
  } size_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        empty_marker_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] pic_width_o;
  logic [31:0] pic_height_o;
  logic [2:0]  status_o;

  h264_sps_dimension_parser dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .last_byte_i,
    .empty_marker_i, .out_valid_o, .out_stall_i, .pic_width_o, .pic_height_o,
    .status_o
  );

  always #1 clk_i = ~clk_i;

  word_t pending_words[$];
  size_t expected_sizes[$];
  int    failures = 0;
  bit    gen_done = 0;

  // Parser shadow state.
  phase_e      ph;
  logic [1:0]  zrun;
  int          gzeros;
  logic [63:0] gval;
  bit          gsuffix;
  int          bleft;
  logic [7:0]  prof;
  logic [1:0]  chroma;
  logic [3:0]  lidx;
  logic [8:0]  cidx;
  logic [7:0]  last_sc;
  logic [7:0]  next_sc;
  logic [1:0]  poc_type;
  logic [31:0] cyc_target;
  logic [31:0] wmbs;
  logic [31:0] hunits;
  logic        frame_only;
  logic [31:0] crop [4];
  logic [2:0]  err;

  function automatic int fixed_len(phase_e p);
    case (p)
      P_PROFILE: return 8;
      P_SKIP16: return 16;
      P_SEP_PLANE, P_BYPASS, P_MATRIX, P_LIST_FLAG, P_DELTA_ZERO, P_GAPS,
      P_FRAME_ONLY, P_MBAFF, P_DIRECT, P_CROP_FLAG: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit chroma_profile(logic [7:0] p);
    case (p)
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128,
      8'd138, 8'd139, 8'd134, 8'd135: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void enter_phase(phase_e p);
    ph = p;
    bleft = fixed_len(p);
    gzeros = 0;
    gval = '0;
    gsuffix = 0;
  endfunction

  function automatic void reset_parser();
    zrun = 0; prof = 0; chroma = 1; lidx = 0; cidx = 0;
    last_sc = 8; next_sc = 8; poc_type = 0; cyc_target = 0;
    wmbs = 0; hunits = 0; frame_only = 0; err = h264sps_pkg::ST_OK;
    for (int i = 0; i < 4; i++) crop[i] = 0;
    enter_phase(P_HEADER);
  endfunction

  function automatic void next_list();
    lidx++;
    enter_phase(lidx >= ((chroma == 2'd3) ? 12 : 8) ? P_FRAME_NUM : P_LIST_FLAG);
  endfunction

  function automatic void advance(logic [63:0] v);
    logic [31:0] delta;
    case (ph)
      P_PROFILE: begin prof = v[7:0]; enter_phase(P_SKIP16); end
      P_SKIP16: enter_phase(P_SPS_ID);
      P_SPS_ID: enter_phase(chroma_profile(prof) ? P_CHROMA_FMT : P_FRAME_NUM);
      P_CHROMA_FMT: begin
        chroma = (v <= 3) ? v[1:0] : 2'd0;
        enter_phase(chroma == 2'd3 ? P_SEP_PLANE : P_BD_LUMA);
      end
      P_SEP_PLANE: enter_phase(P_BD_LUMA);
      P_BD_LUMA: enter_phase(P_BD_CHROMA);
      P_BD_CHROMA: enter_phase(P_BYPASS);
      P_BYPASS: enter_phase(P_MATRIX);
      P_MATRIX: begin lidx = 0; enter_phase(v != 0 ? P_LIST_FLAG : P_FRAME_NUM); end
      P_LIST_FLAG: begin
        if (v != 0) begin
          cidx = 0; last_sc = 8; next_sc = 8;
          enter_phase(P_LIST_DELTA);
        end else begin
          next_list();
        end
      end
      P_LIST_DELTA: begin
        // Signed deltas mapped from ue and applied modulo 256.
        delta = v[0] ? (32'((v + 64'd1) >> 1) & 32'hFF)
                     : ((32'd0 - (32'(v >> 1) & 32'hFF)) & 32'hFF);
        next_sc = 8'(last_sc + delta);
        if (next_sc != 0) last_sc = next_sc;
        cidx++;
        if (cidx >= ((lidx < 6) ? 16 : 64) || next_sc == 0) next_list();
        else enter_phase(P_LIST_DELTA);
      end
      P_FRAME_NUM: enter_phase(P_POC_TYPE);
      P_POC_TYPE: begin
        poc_type = (v == 0) ? 2'd0 : (v == 1) ? 2'd1 : 2'd2;
        enter_phase(poc_type == 0 ? P_POC_LSB : poc_type == 1 ? P_DELTA_ZERO : P_MAX_REF);
      end
      P_POC_LSB: enter_phase(P_MAX_REF);
      P_DELTA_ZERO: enter_phase(P_OFF_NONREF);
      P_OFF_NONREF: enter_phase(P_OFF_TB);
      P_OFF_TB: enter_phase(P_CYCLE_LEN);
      P_CYCLE_LEN: begin
        cyc_target = (v < CycleCap) ? v[31:0] : CycleCap;
        cidx = 0;
        enter_phase(cyc_target != 0 ? P_CYCLE_OFF : P_MAX_REF);
      end
      P_CYCLE_OFF: begin
        cidx++;
        enter_phase(cidx >= cyc_target ? P_MAX_REF : P_CYCLE_OFF);
      end
      P_MAX_REF: enter_phase(P_GAPS);
      P_GAPS: enter_phase(P_WIDTH);
      P_WIDTH: begin wmbs = 32'(v + 64'd1); enter_phase(P_HEIGHT); end
      P_HEIGHT: begin hunits = 32'(v + 64'd1); enter_phase(P_FRAME_ONLY); end
      P_FRAME_ONLY: begin
        frame_only = v[0];
        enter_phase(frame_only ? P_DIRECT : P_MBAFF);
      end
      P_MBAFF: enter_phase(P_DIRECT);
      P_DIRECT: enter_phase(P_CROP_FLAG);
      P_CROP_FLAG: begin lidx = 0; enter_phase(v != 0 ? P_CROP : P_DONE); end
      P_CROP: begin
        crop[lidx[1:0]] = v[31:0];
        lidx++;
        enter_phase(lidx >= 4 ? P_DONE : P_CROP);
      end
      default: ;
    endcase
  endfunction

  function automatic void feed_bit(logic b);
    if (ph == P_HEADER || ph >= P_DONE) return;
    if (fixed_len(ph) != 0) begin
      gval = {gval[62:0], b};
      if (bleft > 0) bleft--;
      if (bleft == 0) advance(gval);
      return;
    end
    if (!gsuffix) begin
      if (b == 1'b0) begin
        gzeros++;
        if (gzeros > 31) begin
          err = h264sps_pkg::ST_TRUNCATED;
          ph = P_SINK;
        end
      end else if (gzeros == 0) begin
        advance(64'd0);
      end else begin
        gsuffix = 1;
        bleft = gzeros;
        gval = '0;
      end
      return;
    end
    gval = {gval[62:0], b};
    if (bleft > 0) bleft--;
    if (bleft == 0) advance(((64'd1 << gzeros) - 64'd1) + gval);
  endfunction

  function automatic void close_unit();
    size_t r;
    logic [63:0] sw, sh, fm, cw, ch, cx, cy;
    r.width = 0;
    r.height = 0;
    if (ph == P_HEADER) begin
      r.status = h264sps_pkg::ST_EMPTY;
    end else if (err != h264sps_pkg::ST_OK) begin
      r.status = err;
    end else if (ph != P_DONE) begin
      r.status = h264sps_pkg::ST_TRUNCATED;
    end else begin
      sw = (chroma == 2'd1 || chroma == 2'd2) ? 2 : 1;
      sh = (chroma == 2'd1) ? 2 : 1;
      fm = frame_only ? 1 : 2;
      cw = 64'(wmbs) * 16;
      ch = 64'(hunits) * 16 * fm;
      cx = sw * 64'(32'(crop[0] + crop[1]));
      cy = sh * fm * 64'(32'(crop[2] + crop[3]));
      if (cx >= cw || cy >= ch) begin
        r.status = h264sps_pkg::ST_CROP;
      end else begin
        r.status = h264sps_pkg::ST_OK;
        r.width = 32'(cw - cx);
        r.height = 32'(ch - cy);
      end
    end
    expected_sizes.push_back(r);
    reset_parser();
  endfunction

  function automatic void predict_word(word_t w);
    if (w.empty) begin
      close_unit();
      return;
    end
    if (ph == P_HEADER) begin
      if (w.data[4:0] == h264sps_pkg::NalTypeSps) enter_phase(P_PROFILE);
      else begin
        err = h264sps_pkg::ST_NOT_SPS;
        ph = P_SINK;
      end
    end else if (zrun >= 2 && w.data == h264sps_pkg::EmulByte) begin
      zrun = 0;
    end else begin
      zrun = (w.data == 0) ? ((zrun < 2) ? zrun + 1 : 2) : 0;
      for (int i = 7; i >= 0; i--) feed_bit(w.data[i]);
    end
    if (w.last) close_unit();
  endfunction

  // Stimulus construction: an SPS is built as a bit string, then packed into
  // bytes with emulation-prevention bytes inserted.
  bit         sps_bits[$];
  logic [7:0] unit_bytes[$];
  bit         drain_next = 0;
  int         unit_count = 0;

  function automatic void put_bits(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(logic [63:0] v);
    logic [63:0] x;
    int len;
    x = v + 1;
    len = 0;
    for (int i = 0; i < 64; i++) if (x[i]) len = i + 1;
    put_bits(0, len - 1);
    put_bits(x, len);
  endfunction

  function automatic void put_se(int d);
    put_ue(d > 0 ? 64'(2 * d - 1) : 64'(-2 * d));
  endfunction

  function automatic logic [63:0] rnd_ue();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 64'hFFFF_FFFE;
    if (r < 8) return 64'($urandom);
    return $urandom_range(0, 20);
  endfunction

  function automatic void push_word(logic [7:0] d, logic l, logic e);
    word_t w;
    w.data = d; w.last = l; w.empty = e; w.drain = drain_next;
    drain_next = 0;
    pending_words.push_back(w);
  endfunction

  function automatic void gen_sps(bit long_code);
    logic [7:0] profs [16] = '{66, 77, 88, 100, 110, 122, 244, 44, 83, 86, 118,
                               128, 138, 139, 134, 135};
    logic [7:0] p, b;
    int cf, lastsc, d, nx, cl, zc;
    bit fo;
    sps_bits.delete();
    unit_bytes.delete();
    p = profs[$urandom_range(0, 15)];
    put_bits(p, 8);
    put_bits($urandom, 16);
    if (long_code) begin
      put_bits(0, 32);
      put_bits($urandom, 17);
    end else begin
      put_ue($urandom_range(0, 31));
      if (chroma_profile(p)) begin
        cf = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        put_ue(cf);
        if (cf > 3) cf = 0;
        if (cf == 3) put_bits($urandom, 1);
        put_ue($urandom_range(0, 6));
        put_ue($urandom_range(0, 6));
        put_bits($urandom, 1);
        if ($urandom_range(0, 2) == 0) begin
          put_bits(1, 1);
          for (int i = 0; i < ((cf == 3) ? 12 : 8); i++) begin
            if ($urandom_range(0, 1) == 0) begin
              put_bits(0, 1);
              continue;
            end
            put_bits(1, 1);
            lastsc = 8;
            for (int j = 0; j < ((i < 6) ? 16 : 64); j++) begin
              d = $urandom_range(0, 16) - 8;
              nx = (lastsc + d) & 255;
              put_se(d);
              if (nx == 0) break;
              lastsc = nx;
            end
          end
        end else begin
          put_bits(0, 1);
        end
      end
      put_ue(rnd_ue());
      d = $urandom_range(0, 3);
      put_ue(d);
      if (d == 0) begin
        put_ue(rnd_ue());
      end else if (d == 1) begin
        put_bits($urandom, 1);
        put_se($urandom_range(0, 200) - 100);
        put_se($urandom_range(0, 200) - 100);
        cl = ($urandom_range(0, 29) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 4);
        put_ue(cl);
        for (int i = 0; i < ((cl < CycleCap) ? cl : CycleCap); i++)
          put_se($urandom_range(0, 20) - 10);
      end
      put_ue($urandom_range(0, 16));
      put_bits($urandom, 1);
      put_ue(($urandom_range(0, 9) == 0) ? rnd_ue() : $urandom_range(0, 120));
      put_ue(($urandom_range(0, 9) == 0) ? rnd_ue() : $urandom_range(0, 68));
      fo = $urandom_range(0, 1);
      put_bits(fo, 1);
      if (!fo) put_bits($urandom, 1);
      put_bits($urandom, 1);
      if ($urandom_range(0, 1) == 1) begin
        put_bits(1, 1);
        for (int i = 0; i < 4; i++)
          put_ue(($urandom_range(0, 9) == 0) ? rnd_ue() : $urandom_range(0, 8));
      end else begin
        put_bits(0, 1);
      end
    end
    put_bits(1, 1);
    while (sps_bits.size() % 8 != 0) sps_bits.push_back(1'b0);
    unit_bytes.push_back({3'($urandom), h264sps_pkg::NalTypeSps});
    zc = 0;
    for (int i = 0; i < sps_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = sps_bits[i + k];
      if (zc >= 2 && b <= 8'd3) begin
        unit_bytes.push_back(h264sps_pkg::EmulByte);
        zc = 0;
      end
      unit_bytes.push_back(b);
      zc = (b == 0) ? zc + 1 : 0;
    end
  endfunction

  // How the unit ends: whole, cut short, closed by an empty marker, or padded.
  function automatic void send_unit(int how);
    int n;
    unit_count++;
    if (unit_count == 30) drain_next = 1;
    if (how == 3) repeat ($urandom_range(1, 3)) unit_bytes.push_back(8'($urandom));
    n = unit_bytes.size();
    if (how == 1) n = $urandom_range(1, unit_bytes.size() - 1);
    if (how == 2) n = $urandom_range(0, unit_bytes.size());
    for (int i = 0; i < n; i++)
      push_word(unit_bytes[i], how != 2 && i == n - 1, 1'b0);
    if (how == 2) push_word(8'($urandom), 1'($urandom), 1'b1);
  endfunction

  function automatic void gen_garbage(bit sps_type);
    logic [7:0] h;
    logic [7:0] pick [4];
    unit_bytes.delete();
    h = 8'($urandom);
    if (sps_type) h[4:0] = h264sps_pkg::NalTypeSps;
    else if (h[4:0] == h264sps_pkg::NalTypeSps) h[0] = ~h[0];
    unit_bytes.push_back(h);
    repeat ($urandom_range(1, 12)) begin
      pick = '{8'h00, 8'h00, h264sps_pkg::EmulByte, 8'($urandom)};
      unit_bytes.push_back(pick[$urandom_range(0, 3)]);
    end
  endfunction

  initial begin
    int r;
    reset_parser();
    // Directed units.
    unit_bytes.delete();
    send_unit(2);
    gen_garbage(0);
    send_unit(0);
    gen_sps(1);
    send_unit(0);
    gen_sps(0);
    send_unit(0);
    while (pending_words.size() < 750) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        unit_bytes.delete();
        send_unit(2);
      end else if (r < 9) begin
        gen_garbage(0);
        send_unit(0);
      end else if (r < 13) begin
        gen_garbage(1);
        send_unit(0);
      end else if (r < 16) begin
        gen_sps(1);
        send_unit(0);
      end else begin
        gen_sps(0);
        r = $urandom_range(0, 9);
        send_unit(r < 7 ? 0 : r - 6);
      end
    end
    gen_done = 1;
  end

  // Sender: bursts of words separated by random gaps.
  word_t cur_word;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= 8'd0;
      last_byte_i <= 1'b0;
      empty_marker_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_word(cur_word);
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && expected_sizes.size() > 0)) begin
          cur_word = pending_words.pop_front();
          data_byte_i <= cur_word.data;
          last_byte_i <= cur_word.last;
          empty_marker_i <= cur_word.empty;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall density changes every window, plus one long hold-off.
  int rx_cycles = 0;
  int win_left = 0;
  int stall_pct = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles >= 3000 && rx_cycles < 5000) begin
        out_stall_i <= 1'b1;
      end else begin
        if (win_left == 0) begin
          win_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        win_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    size_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sizes.size() == 0) begin
        $display("%0t: unexpected result w=%0d h=%0d status=%0d", $time,
                 pic_width_o, pic_height_o, status_o);
        failures++;
      end else begin
        e = expected_sizes.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          failures++;
        end
        if (pic_width_o !== e.width) begin
          $display("%0t: width expected %0d actual %0d", $time, e.width, pic_width_o);
          failures++;
        end
        if (pic_height_o !== e.height) begin
          $display("%0t: height expected %0d actual %0d", $time, e.height, pic_height_o);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!gen_done || pending_words.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_sizes.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (failures == 0 && expected_sizes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
